[sv/ddec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta instruction decoder package
// Shared types and constants of the delta instruction decoder and its checker.
// ----------------------------------------------------------------------------
package ddec_pkg;

   // Smallest number of bytes a well-formed delta stream may carry.
   localparam logic [2:0] MIN_DELTA_BYTES = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_SOURCE_SIZE = 1'b0;
   localparam logic CSR_TARGET_SIZE = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_COPY     = 2'd0;
   localparam logic [1:0] KIND_LITERAL  = 2'd1;
   localparam logic [1:0] KIND_FINISHED = 2'd2;
   localparam logic [1:0] KIND_FAILED   = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_ZERO_CMD     = 3'd1;
   localparam logic [2:0] ERR_COPY_SOURCE  = 3'd2;
   localparam logic [2:0] ERR_COPY_TARGET  = 3'd3;
   localparam logic [2:0] ERR_LIT_TARGET   = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED    = 3'd5;
   localparam logic [2:0] ERR_TOO_SHORT    = 3'd6;

   // A copy whose collected length is zero moves this many bytes.
   localparam logic [23:0] COPY_LEN_ZERO = 24'h010000;

   // Result queue.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_CMD  = 4'b0001,
      PH_OPER = 4'b0010,
      PH_LIT  = 4'b0100,
      PH_DROP = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] copy_offset;
      logic [23:0] copy_length;
      logic [7:0]  literal_value;
      logic [2:0]  error_code;
      logic        run_end;
   } rsp_type;

endpackage

[sv/delta_instruction_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta instruction decoder
// Decodes the instruction bytes of a binary delta into copy descriptors,
// literal bytes and a final status.
// ----------------------------------------------------------------------------
// The decoder takes one byte of the delta instruction stream per cycle and
// decodes it in a single pass against the stream state, writing the zero, one
// or two results it causes into a four-entry result queue. A byte can be taken
// every cycle as long as the queue has room for two results; req_stall rises
// while more than two results wait. A byte that both closes a command and
// ends the stream gives two results, which leave the queue one by one, so the
// sustained rate is one byte per cycle except where the consumer stalls or
// such double results pile up. source_size takes effect at once; target_size
// is sampled on the first byte of each stream.
module delta_instruction_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_delta_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_copy_offset,
   output logic [23:0] rsp_copy_length,
   output logic [7:0]  rsp_literal_value,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_run_end,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   logic [31:0] source_size_ff;
   logic [31:0] target_size_ff;

   ddec_pkg::phase_type phase_ff, phase_in;
   logic [6:0]  pending_ff, pending_in;
   logic [31:0] offset_ff, offset_in;
   logic [23:0] length_ff, length_in;
   logic [6:0]  literal_left_ff, literal_left_in;
   logic [31:0] target_left_ff, target_left_in;
   logic [2:0]  bytes_seen_ff, bytes_seen_in;
   logic        failed_ff, failed_in;

   ddec_pkg::rsp_type mem_ff [ddec_pkg::RSP_DEPTH];
   logic [ddec_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ddec_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ddec_pkg::RSP_CNT_W-1:0] count_ff, count_in;

   logic        accept;
   logic        pop;
   logic [31:0] tgt_eff;
   logic [6:0]  lowest;
   logic        do_finish;
   logic [31:0] fin_off;
   logic [23:0] fin_len;
   logic [23:0] len_eff;
   logic [32:0] copy_end;
   logic        body_valid;
   ddec_pkg::rsp_type body_res;
   logic        end_valid;
   ddec_pkg::rsp_type end_res;
   ddec_pkg::rsp_type res_a;
   ddec_pkg::rsp_type res_b;
   logic [1:0]  push_cnt;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = count_ff > ddec_pkg::RSP_CNT_W'(ddec_pkg::RSP_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid & ~rsp_stall;

   assign rsp_kind          = mem_ff[rd_ptr_ff].kind;
   assign rsp_copy_offset   = mem_ff[rd_ptr_ff].copy_offset;
   assign rsp_copy_length   = mem_ff[rd_ptr_ff].copy_length;
   assign rsp_literal_value = mem_ff[rd_ptr_ff].literal_value;
   assign rsp_error_code    = mem_ff[rd_ptr_ff].error_code;
   assign rsp_run_end       = mem_ff[rd_ptr_ff].run_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_size_ff <= '0;
         target_size_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ddec_pkg::CSR_SOURCE_SIZE: source_size_ff <= csr_write_data;
            ddec_pkg::CSR_TARGET_SIZE: target_size_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Decode of one byte: the command body first, then the end-of-stream check.
   always_comb begin
      phase_in        = phase_ff;
      pending_in      = pending_ff;
      offset_in       = offset_ff;
      length_in       = length_ff;
      literal_left_in = literal_left_ff;
      failed_in       = failed_ff;
      body_valid      = 1'b0;
      body_res        = '0;
      end_valid       = 1'b0;
      end_res         = '0;
      do_finish       = 1'b0;
      fin_off         = offset_ff;
      fin_len         = length_ff;

      // The first byte of a stream picks up the target size.
      tgt_eff        = (bytes_seen_ff == '0) ? target_size_ff : target_left_ff;
      target_left_in = tgt_eff;
      bytes_seen_in  = (bytes_seen_ff == 3'd7) ? bytes_seen_ff : bytes_seen_ff + 3'd1;

      lowest = pending_ff & (~pending_ff + 7'd1);

      unique case (phase_ff)
         ddec_pkg::PH_CMD: begin
            if (req_delta_byte[7]) begin
               pending_in = req_delta_byte[6:0];
               offset_in  = '0;
               length_in  = '0;
               fin_off    = '0;
               fin_len    = '0;
               if (req_delta_byte[6:0] == '0) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = ddec_pkg::PH_OPER;
               end
            end else if (req_delta_byte != '0) begin
               if ({24'd0, req_delta_byte} > tgt_eff) begin
                  body_valid          = 1'b1;
                  body_res.kind       = ddec_pkg::KIND_FAILED;
                  body_res.error_code = ddec_pkg::ERR_LIT_TARGET;
               end else begin
                  target_left_in  = tgt_eff - {24'd0, req_delta_byte};
                  literal_left_in = req_delta_byte[6:0];
                  phase_in        = ddec_pkg::PH_LIT;
               end
            end else begin
               body_valid          = 1'b1;
               body_res.kind       = ddec_pkg::KIND_FAILED;
               body_res.error_code = ddec_pkg::ERR_ZERO_CMD;
            end
         end
         ddec_pkg::PH_OPER: begin
            // Operand bytes arrive in flag order, lowest flag first.
            for (int i = 0; i < 4; i++) begin
               if (lowest[i]) fin_off[8*i +: 8] = offset_ff[8*i +: 8] | req_delta_byte;
            end
            for (int i = 0; i < 3; i++) begin
               if (lowest[4+i]) fin_len[8*i +: 8] = length_ff[8*i +: 8] | req_delta_byte;
            end
            offset_in  = fin_off;
            length_in  = fin_len;
            pending_in = pending_ff & ~lowest;
            do_finish  = (pending_ff & ~lowest) == '0;
         end
         ddec_pkg::PH_LIT: begin
            body_valid             = 1'b1;
            body_res.kind          = ddec_pkg::KIND_LITERAL;
            body_res.literal_value = req_delta_byte;
            if (literal_left_ff != '0) literal_left_in = literal_left_ff - 7'd1;
            if (literal_left_in == '0) phase_in = ddec_pkg::PH_CMD;
         end
         ddec_pkg::PH_DROP: ;
         default: ;
      endcase

      len_eff  = (fin_len == '0) ? ddec_pkg::COPY_LEN_ZERO : fin_len;
      copy_end = {1'b0, fin_off} + {9'd0, len_eff};

      if (do_finish) begin
         body_valid = 1'b1;
         if (copy_end > {1'b0, source_size_ff}) begin
            body_res.kind       = ddec_pkg::KIND_FAILED;
            body_res.error_code = ddec_pkg::ERR_COPY_SOURCE;
         end else if ({8'd0, len_eff} > tgt_eff) begin
            body_res.kind       = ddec_pkg::KIND_FAILED;
            body_res.error_code = ddec_pkg::ERR_COPY_TARGET;
         end else begin
            body_res.kind        = ddec_pkg::KIND_COPY;
            body_res.copy_offset = fin_off;
            body_res.copy_length = len_eff;
            target_left_in       = tgt_eff - {8'd0, len_eff};
            phase_in             = ddec_pkg::PH_CMD;
         end
      end

      if (body_valid && body_res.kind == ddec_pkg::KIND_FAILED) begin
         failed_in = 1'b1;
         phase_in  = ddec_pkg::PH_DROP;
      end

      if (req_final_byte) begin
         if (!failed_in) begin
            end_valid = 1'b1;
            if (bytes_seen_in < ddec_pkg::MIN_DELTA_BYTES) begin
               end_res.kind       = ddec_pkg::KIND_FAILED;
               end_res.error_code = ddec_pkg::ERR_TOO_SHORT;
            end else if (phase_in != ddec_pkg::PH_CMD || target_left_in != '0) begin
               end_res.kind       = ddec_pkg::KIND_FAILED;
               end_res.error_code = ddec_pkg::ERR_TRUNCATED;
            end else begin
               end_res.kind = ddec_pkg::KIND_FINISHED;
            end
         end
         // Back to the clean state for the next stream.
         phase_in        = ddec_pkg::PH_CMD;
         pending_in      = '0;
         offset_in       = '0;
         length_in       = '0;
         literal_left_in = '0;
         target_left_in  = '0;
         bytes_seen_in   = '0;
         failed_in       = 1'b0;
      end

      end_res.run_end = 1'b1;
      if (body_valid) begin
         res_a         = body_res;
         res_a.run_end = ~end_valid;
      end else begin
         res_a = end_res;
      end
      res_b    = end_res;
      push_cnt = {1'b0, body_valid} + {1'b0, end_valid};
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + ddec_pkg::RSP_PTR_W'(push_cnt);
         count_in  = count_ff + ddec_pkg::RSP_CNT_W'(push_cnt);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + ddec_pkg::RSP_PTR_W'(1);
         count_in  = count_in - ddec_pkg::RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (push_cnt != 2'd0) mem_ff[wr_ptr_ff] <= res_a;
         if (push_cnt == 2'd2) mem_ff[wr_ptr_ff + ddec_pkg::RSP_PTR_W'(1)] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ddec_pkg::PH_CMD;
         pending_ff      <= '0;
         offset_ff       <= '0;
         length_ff       <= '0;
         literal_left_ff <= '0;
         target_left_ff  <= '0;
         bytes_seen_ff   <= '0;
         failed_ff       <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (accept) begin
            phase_ff        <= phase_in;
            pending_ff      <= pending_in;
            offset_ff       <= offset_in;
            length_ff       <= length_in;
            literal_left_ff <= literal_left_in;
            target_left_ff  <= target_left_in;
            bytes_seen_ff   <= bytes_seen_in;
            failed_ff       <= failed_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/ddec_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta instruction decoder checker
// Port-level assertions on the result channel of the decoder.
// ----------------------------------------------------------------------------
module ddec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_copy_offset,
   input logic [23:0] rsp_copy_length,
   input logic [7:0]  rsp_literal_value,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_run_end
);

   // A result beat that is held back keeps its kind, error code, offset and literal value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_error_code)
         && $stable(rsp_copy_offset) && $stable(rsp_literal_value))
      else $error("result beat changed while stalled");

   // Nothing is left in the result queue right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A copy always moves at least one byte and carries no error.
   a_copy_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ddec_pkg::KIND_COPY |->
         rsp_copy_length != '0 && rsp_error_code == ddec_pkg::ERR_NONE)
      else $error("malformed copy descriptor");

   // A failure or finish status closes its byte's results; only a failure has an error code.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == ddec_pkg::KIND_FAILED || rsp_kind == ddec_pkg::KIND_FINISHED)
         |-> rsp_run_end && ((rsp_kind == ddec_pkg::KIND_FAILED) == (rsp_error_code != '0)))
      else $error("status beat is not last or has a wrong error code");

endmodule

bind delta_instruction_decoder ddec_checker u_ddec_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta instruction decoder testbench
// Drives delta instruction streams into the decoder, first from a short table
// of hand-picked bytes and then as random streams. Most random streams are
// well formed for the current source and target sizes; the rest are cut
// short, corrupted, overrun or plain noise. A byte-level decoder model in
// this file predicts every copy descriptor, literal byte and end status, and
// each result beat is checked in order against that prediction. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_BEATS  = 1950;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 20;

   typedef struct {
      logic [7:0]        data;
      logic              last;
      logic              reconfig;
      logic              typed;
      ddec_pkg::rsp_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_delta_byte = 8'd0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_copy_offset;
   logic [23:0] rsp_copy_length;
   logic [7:0]  rsp_literal_value;
   logic [2:0]  rsp_error_code;
   logic        rsp_run_end;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = ddec_pkg::CSR_SOURCE_SIZE;
   logic [31:0] csr_write_data = 32'd0;

   // Decoder model: register copies and per-stream state.
   logic [31:0] cfg_source_size;
   logic [31:0] cfg_target_size;
   ddec_pkg::phase_type dec_phase;
   logic [6:0]  dec_pending;
   logic [31:0] dec_offset;
   logic [23:0] dec_length;
   logic [6:0]  dec_lit_left;
   logic [31:0] dec_target_left;
   logic [2:0]  dec_seen;
   logic        dec_failed;

   ddec_pkg::rsp_type step_results[$];
   ddec_pkg::rsp_type decoded_results[$];
   logic [7:0] stream_q[$];
   directed_row_type directed_rows[26];

   ddec_pkg::rsp_type got_rsp;
   ddec_pkg::rsp_type want_rsp;
   int mismatch_count = 0;
   int results_checked = 0;
   int kind_seen[4] = '{0, 0, 0, 0};
   int beats_sent = 0;
   int streams_sent = 0;
   int settings_used = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   logic calm = 1'b0;

   delta_instruction_decoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_delta_byte    (req_delta_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_copy_offset   (rsp_copy_offset),
      .rsp_copy_length   (rsp_copy_length),
      .rsp_literal_value (rsp_literal_value),
      .rsp_error_code    (rsp_error_code),
      .rsp_run_end       (rsp_run_end),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic void emit_result(logic [1:0] kind_v, logic [31:0] off_v,
                                       logic [23:0] len_v, logic [7:0] lit_v,
                                       logic [2:0] err_v);
      ddec_pkg::rsp_type r;
      r.kind          = kind_v;
      r.copy_offset   = off_v;
      r.copy_length   = len_v;
      r.literal_value = lit_v;
      r.error_code    = err_v;
      r.run_end       = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void fail_stream(logic [2:0] code);
      dec_failed = 1'b1;
      dec_phase  = ddec_pkg::PH_DROP;
      emit_result(ddec_pkg::KIND_FAILED, 32'd0, 24'd0, 8'd0, code);
   endfunction

   function automatic void clear_stream();
      dec_phase       = ddec_pkg::PH_CMD;
      dec_pending     = 7'd0;
      dec_offset      = 32'd0;
      dec_length      = 24'd0;
      dec_lit_left    = 7'd0;
      dec_target_left = 32'd0;
      dec_seen        = 3'd0;
      dec_failed      = 1'b0;
   endfunction

   // The source check is done on 33 bits so that offset plus length cannot wrap.
   function automatic void close_copy();
      logic [23:0] len_v;
      len_v = (dec_length == 24'd0) ? ddec_pkg::COPY_LEN_ZERO : dec_length;
      if ({1'b0, dec_offset} + {9'd0, len_v} > {1'b0, cfg_source_size}) begin
         fail_stream(ddec_pkg::ERR_COPY_SOURCE);
      end else if ({8'd0, len_v} > dec_target_left) begin
         fail_stream(ddec_pkg::ERR_COPY_TARGET);
      end else begin
         dec_target_left = dec_target_left - {8'd0, len_v};
         dec_phase = ddec_pkg::PH_CMD;
         emit_result(ddec_pkg::KIND_COPY, dec_offset, len_v, 8'd0, ddec_pkg::ERR_NONE);
      end
   endfunction

   function automatic void decode_delta_byte(logic [7:0] b, logic last);
      int fld;
      ddec_pkg::rsp_type r;
      step_results.delete();
      if (dec_seen == 3'd0) dec_target_left = cfg_target_size;
      if (dec_seen < 3'd7) dec_seen = dec_seen + 3'd1;
      case (dec_phase)
         ddec_pkg::PH_CMD: begin
            if (b[7]) begin
               dec_pending = b[6:0];
               dec_offset  = 32'd0;
               dec_length  = 24'd0;
               if (dec_pending == 7'd0) close_copy();
               else dec_phase = ddec_pkg::PH_OPER;
            end else if (b != 8'd0) begin
               if ({24'd0, b} > dec_target_left) begin
                  fail_stream(ddec_pkg::ERR_LIT_TARGET);
               end else begin
                  dec_target_left = dec_target_left - {24'd0, b};
                  dec_lit_left = b[6:0];
                  dec_phase = ddec_pkg::PH_LIT;
               end
            end else begin
               fail_stream(ddec_pkg::ERR_ZERO_CMD);
            end
         end
         ddec_pkg::PH_OPER: begin
            // Operand bytes arrive in flag order, lowest flag first.
            fld = 0;
            while (fld < 7 && !dec_pending[fld]) fld++;
            if (fld < 4) dec_offset = dec_offset | ({24'd0, b} << (8 * fld));
            else if (fld < 7) dec_length = dec_length | ({16'd0, b} << (8 * (fld - 4)));
            if (fld < 7) dec_pending[fld] = 1'b0;
            if (dec_pending == 7'd0) close_copy();
         end
         ddec_pkg::PH_LIT: begin
            emit_result(ddec_pkg::KIND_LITERAL, 32'd0, 24'd0, b, ddec_pkg::ERR_NONE);
            if (dec_lit_left != 7'd0) dec_lit_left = dec_lit_left - 7'd1;
            if (dec_lit_left == 7'd0) dec_phase = ddec_pkg::PH_CMD;
         end
         default: begin
         end
      endcase
      if (last) begin
         if (!dec_failed) begin
            if (dec_seen < ddec_pkg::MIN_DELTA_BYTES)
               fail_stream(ddec_pkg::ERR_TOO_SHORT);
            else if (dec_phase != ddec_pkg::PH_CMD || dec_target_left != 32'd0)
               fail_stream(ddec_pkg::ERR_TRUNCATED);
            else
               emit_result(ddec_pkg::KIND_FINISHED, 32'd0, 24'd0, 8'd0, ddec_pkg::ERR_NONE);
         end
         clear_stream();
      end
      if (step_results.size() != 0) begin
         r = step_results.pop_back();
         r.run_end = 1'b1;
         step_results.push_back(r);
      end
   endfunction

   // Hands one beat to the decoder and records the results it should cause.
   task automatic send_beat(input logic [7:0] b, input logic last, input logic typed,
                            input ddec_pkg::rsp_type want);
      int gap;
      gap = (!calm && $urandom_range(0, 99) < 35) ? gap_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_delta_byte <= b;
      req_final_byte <= last;
      do @(posedge clock); while (req_stall);
      decode_delta_byte(b, last);
      if (typed) decoded_results.push_back(want);
      else foreach (step_results[i]) decoded_results.push_back(step_results[i]);
      beats_sent++;
      if (last) streams_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (decoded_results.size() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] src, input logic [31:0] tgt);
      wait_for_results();
      // A discarded byte may still be in flight with nothing left to expect.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= ddec_pkg::CSR_SOURCE_SIZE;
      csr_write_data   <= src;
      @(posedge clock);
      csr_index        <= ddec_pkg::CSR_TARGET_SIZE;
      csr_write_data   <= tgt;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_source_size = src;
      cfg_target_size = tgt;
      settings_used++;
   endtask

   // Builds one stream into stream_q, most of them well formed for the current
   // sizes; the final flag goes on its last byte.
   task automatic build_stream();
      longint unsigned remaining;
      longint unsigned src;
      longint unsigned len;
      longint unsigned off;
      int cap;
      int cnt;
      int mode;
      logic [6:0] flags;
      logic [7:0] opnd[$];
      stream_q.delete();
      mode = $urandom_range(0, 99);
      if (mode < 6) begin
         repeat ($urandom_range(1, 10)) stream_q.push_back(8'($urandom));
         return;
      end
      remaining = cfg_target_size;
      src = cfg_source_size;
      cap = $urandom_range(4, 80);
      while (remaining != 0 && stream_q.size() < cap) begin
         if (src != 0 && $urandom_range(0, 1) == 1) begin
            len = (remaining < src) ? remaining : src;
            if (len >= 65536 && $urandom_range(0, 4) < 2) len = 65536;
            else len = $urandom_range(1, (len > 4096) ? 32'd4096 : 32'(len));
            if ($urandom_range(0, 4) == 0) off = src - len;
            else off = {$urandom(), $urandom()} % (src - len + 1);
            flags = 7'd0;
            opnd.delete();
            for (int i = 0; i < 4; i++) begin
               if (off[8 * i +: 8] != 8'd0 || $urandom_range(0, 3) == 0) begin
                  flags[i] = 1'b1;
                  opnd.push_back(off[8 * i +: 8]);
               end
            end
            // A full 64 KiB copy may also be sent with no length bytes at all.
            if (!(len == 65536 && $urandom_range(0, 1) == 1)) begin
               for (int i = 0; i < 3; i++) begin
                  if (len[8 * i +: 8] != 8'd0 || $urandom_range(0, 3) == 0) begin
                     flags[4 + i] = 1'b1;
                     opnd.push_back(len[8 * i +: 8]);
                  end
               end
            end
            stream_q.push_back({1'b1, flags});
            foreach (opnd[j]) stream_q.push_back(opnd[j]);
            remaining = remaining - len;
         end else begin
            cnt = $urandom_range(1, (remaining < 127) ? 32'(remaining) : 32'd127);
            stream_q.push_back(8'(cnt));
            repeat (cnt) stream_q.push_back(8'($urandom));
            remaining = remaining - cnt;
         end
      end
      if (stream_q.size() == 0) begin
         repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
      end else if (mode < 26) begin
         case ($urandom_range(0, 2))
            0: stream_q = stream_q[0:$urandom_range(0, stream_q.size() - 1)];
            1: stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom);
            default: repeat ($urandom_range(1, 4)) stream_q.push_back(8'($urandom));
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
         stall_left <= gap_len() - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rsp = {rsp_kind, rsp_copy_offset, rsp_copy_length, rsp_literal_value,
                    rsp_error_code, rsp_run_end};
         if (decoded_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: %0t unexpected result kind=%0d off=%h len=%h lit=%h err=%0d end=%b",
                        $realtime, got_rsp.kind, got_rsp.copy_offset, got_rsp.copy_length,
                        got_rsp.literal_value, got_rsp.error_code, got_rsp.run_end);
         end else begin
            want_rsp = decoded_results.pop_front();
            results_checked++;
            kind_seen[got_rsp.kind]++;
            if (got_rsp.kind !== want_rsp.kind || got_rsp.copy_offset !== want_rsp.copy_offset
                || got_rsp.copy_length !== want_rsp.copy_length
                || got_rsp.literal_value !== want_rsp.literal_value
                || got_rsp.error_code !== want_rsp.error_code
                || got_rsp.run_end !== want_rsp.run_end) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR: %0t expected kind=%0d off=%h len=%h lit=%h err=%0d end=%b",
                           $realtime, want_rsp.kind, want_rsp.copy_offset,
                           want_rsp.copy_length, want_rsp.literal_value,
                           want_rsp.error_code, want_rsp.run_end);
                  $display("       actual   kind=%0d off=%h len=%h lit=%h err=%0d end=%b",
                           got_rsp.kind, got_rsp.copy_offset, got_rsp.copy_length,
                           got_rsp.literal_value, got_rsp.error_code, got_rsp.run_end);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("ERROR: no beat moved for %0d cycles, %0d results still expected",
                  IDLE_LIMIT, decoded_results.size());
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_beats;
      int streams_left;
      int setting_idx;
      random_beats = 0;
      streams_left = 0;
      setting_idx  = 0;
      cfg_source_size = 32'd0;
      cfg_target_size = 32'd0;
      clear_stream();

      // Hand-picked streams. The first three run with the sizes left at zero
      // by reset; the rest with the largest source and a target of 64 KiB + 16.
      directed_rows = '{
         '{8'h00, 1'b1, 1'b0, 1'b1, {ddec_pkg::KIND_FAILED, 32'd0, 24'd0, 8'd0,
                                     ddec_pkg::ERR_ZERO_CMD, 1'b1}},
         '{8'h05, 1'b1, 1'b0, 1'b1, {ddec_pkg::KIND_FAILED, 32'd0, 24'd0, 8'd0,
                                     ddec_pkg::ERR_LIT_TARGET, 1'b1}},
         '{8'h80, 1'b1, 1'b0, 1'b1, {ddec_pkg::KIND_FAILED, 32'd0, 24'd0, 8'd0,
                                     ddec_pkg::ERR_COPY_SOURCE, 1'b1}},
         '{8'h01, 1'b0, 1'b1, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, 1'b1, {ddec_pkg::KIND_LITERAL, 32'd0, 24'd0, 8'hFF,
                                     ddec_pkg::ERR_NONE, 1'b1}},
         '{8'h80, 1'b0, 1'b0, 1'b1, {ddec_pkg::KIND_COPY, 32'd0, ddec_pkg::COPY_LEN_ZERO,
                                     8'd0, ddec_pkg::ERR_NONE, 1'b1}},
         '{8'h91, 1'b0, 1'b0, 1'b0, '0},
         '{8'h05, 1'b0, 1'b0, 1'b0, '0},
         '{8'h0F, 1'b1, 1'b0, 1'b0, '0},
         // Offset at its maximum: the source check must not wrap.
         '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
         '{8'h01, 1'b0, 1'b0, 1'b0, '0},
         '{8'h00, 1'b0, 1'b0, 1'b0, '0},
         '{8'h00, 1'b1, 1'b0, 1'b1, {ddec_pkg::KIND_FAILED, 32'd0, 24'd0, 8'd0,
                                     ddec_pkg::ERR_COPY_SOURCE, 1'b1}},
         '{8'hC0, 1'b0, 1'b0, 1'b0, '0},
         '{8'h02, 1'b1, 1'b0, 1'b1, {ddec_pkg::KIND_FAILED, 32'd0, 24'd0, 8'd0,
                                     ddec_pkg::ERR_COPY_TARGET, 1'b1}},
         '{8'h02, 1'b0, 1'b0, 1'b0, '0},
         '{8'h11, 1'b0, 1'b0, 1'b0, '0},
         '{8'h22, 1'b1, 1'b0, 1'b0, '0},
         '{8'h01, 1'b0, 1'b0, 1'b0, '0},
         '{8'h33, 1'b0, 1'b0, 1'b0, '0},
         '{8'h01, 1'b0, 1'b0, 1'b0, '0},
         '{8'h44, 1'b1, 1'b0, 1'b0, '0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].reconfig) configure(32'hFFFF_FFFF, 32'h0001_0010);
         send_beat(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].want);
      end

      while (random_beats < RANDOM_BEATS) begin
         if (streams_left == 0) begin
            case ((setting_idx < 4) ? setting_idx : $urandom_range(0, 4))
               0: configure(32'd0, 32'd0);
               1: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
               2: configure($urandom_range(64, 4096), $urandom_range(4, 60));
               3: configure(32'h0003_0000 + $urandom_range(0, 255),
                            32'h0001_0000 * $urandom_range(1, 2) + $urandom_range(0, 40));
               default: configure($urandom(), $urandom_range(4, 120));
            endcase
            setting_idx++;
            streams_left = $urandom_range(4, 10);
         end
         if ($urandom_range(0, 9) == 0) calm = !calm;
         build_stream();
         foreach (stream_q[i]) begin
            random_beats++;
            send_beat(stream_q[i], i == stream_q.size() - 1, 1'b0, '0);
         end
         streams_left--;
         if ($urandom_range(0, 39) == 0) wait_for_results();
      end

      wait_for_results();
      repeat (END_CYCLES) @(posedge clock);
      mismatch_count += decoded_results.size();

      $display("Sent %0d beats in %0d streams under %0d size settings; checked %0d results.",
               beats_sent, streams_sent, settings_used, results_checked);
      $display("Result mix: %0d copies, %0d literal bytes, %0d clean ends, %0d errors.",
               kind_seen[ddec_pkg::KIND_COPY], kind_seen[ddec_pkg::KIND_LITERAL],
               kind_seen[ddec_pkg::KIND_FINISHED], kind_seen[ddec_pkg::KIND_FAILED]);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
sv/ddec_pkg.sv
sv/delta_instruction_decoder.sv
sv/ddec_checker.sv
tb/tb_top.sv
